[design/xxh64_pkg.sv]
package xxh64_pkg;

	localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
	localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
	localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
	localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
	localparam logic [63:0] PRIME5 = 64'd2870177450012600261;
	localparam logic [63:0] PRIME12 = PRIME1 + PRIME2;

	// multiplier constant select
	typedef logic [2:0] csel_t;
	localparam csel_t C_P1 = 3'd0;
	localparam csel_t C_P2 = 3'd1;
	localparam csel_t C_P3 = 3'd2;
	localparam csel_t C_P5 = 3'd3;

	function automatic logic [63:0] prime_of(input csel_t sel);
		logic [63:0] r;
		case (sel)
			C_P1: r = PRIME1;
			C_P2: r = PRIME2;
			C_P3: r = PRIME3;
			C_P5: r = PRIME5;
			default: r = PRIME1;
		endcase
		return r;
	endfunction

	// rotate left, n in 1..63
	function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] n);
		logic [6:0] rn;
		rn = 7'd64 - {1'b0, n};
		return (x << n) | (x >> rn);
	endfunction

endpackage

[design/xxh64_ifs.sv]
interface xxh64_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;
	modport source (output valid, output data_byte, output byte_valid, output last, input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last, output ready);
endinterface

interface xxh64_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

[design/xxh64_stream_hash.sv]
// A byte beat that fills a stripe starts four lane rounds. A last beat starts the finish:
// lane merge (32 bytes or more only), length add, tail steps, then avalanche and output;
//   one shared 32x32 multiplier, three passes per 64-bit product, serves all of these
//   steps.
// Throughput: ready is high only between beats while the sequencer is idle.
// Reset: arst_n clears seed, length and control state at once; the stripe buffer is not cleared.
module xxh64_stream_hash (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [63:0]          cfg_wdata,
	xxh64_byte_if.sink           byte_in,
	xxh64_hash_if.source         hash_out
);

	localparam logic [5:0] S_IDLE = 6'd0;
	localparam logic [5:0] S_LDA  = 6'd1;
	localparam logic [5:0] S_LDB  = 6'd2;
	localparam logic [5:0] S_M0   = 6'd3;
	localparam logic [5:0] S_M1   = 6'd4;
	localparam logic [5:0] S_M2   = 6'd5;
	localparam logic [5:0] S_SR0  = 6'd6;
	localparam logic [5:0] S_SR1  = 6'd7;
	localparam logic [5:0] S_SR2  = 6'd8;
	localparam logic [5:0] S_SR3  = 6'd9;
	localparam logic [5:0] S_FIN  = 6'd10;
	localparam logic [5:0] S_MSUM = 6'd11;
	localparam logic [5:0] S_MG1  = 6'd12;
	localparam logic [5:0] S_MG2  = 6'd13;
	localparam logic [5:0] S_MG3  = 6'd14;
	localparam logic [5:0] S_MG4  = 6'd15;
	localparam logic [5:0] S_FADD = 6'd16;
	localparam logic [5:0] S_TAIL = 6'd17;
	localparam logic [5:0] S_T8A  = 6'd18;
	localparam logic [5:0] S_T8B  = 6'd19;
	localparam logic [5:0] S_T8C  = 6'd20;
	localparam logic [5:0] S_T8D  = 6'd21;
	localparam logic [5:0] S_T4A  = 6'd22;
	localparam logic [5:0] S_T4B  = 6'd23;
	localparam logic [5:0] S_T4C  = 6'd24;
	localparam logic [5:0] S_T1A  = 6'd25;
	localparam logic [5:0] S_T1B  = 6'd26;
	localparam logic [5:0] S_T1C  = 6'd27;
	localparam logic [5:0] S_AV1  = 6'd28;
	localparam logic [5:0] S_AV2  = 6'd29;
	localparam logic [5:0] S_AV3  = 6'd30;
	localparam logic [5:0] S_OUTW = 6'd31;

	logic [5:0]  st_q, ret_q, ld_ret_q;
	logic [63:0] seed_q, len_q, h_q, w_q, p_q, mul_a_q, hash_q;
	logic [63:0] lane_q [4];
	xxh64_pkg::csel_t mc_q;
	logic        start_q, pend_q, ov_q;
	logic [1:0]  k_q;
	logic [5:0]  pos_q;
	logic [4:0]  ld_addr_q;
	logic [3:0]  ld_cnt_q, ld_n_q;
	logic [7:0]  rd_q;
	logic [7:0]  mem [32];

	logic        acc_in;
	logic [4:0]  tail;
	logic [63:0] mc, lane_k, lane_rot;
	logic [31:0] mx, my;
	logic [63:0] mprod;

	assign byte_in.ready       = (st_q == S_IDLE);
	assign acc_in              = byte_in.valid && byte_in.ready;
	assign hash_out.valid      = ov_q;
	assign hash_out.hash_value = hash_q;
	assign tail                = len_q[4:0];
	assign lane_k              = lane_q[k_q];

	// shared multiplier operand select: three 32x32 partial products per 64-bit multiply
	always_comb begin
		mc = xxh64_pkg::prime_of(mc_q);
		case (st_q)
			S_M1: begin
				mx = mul_a_q[31:0];
				my = mc[63:32];
			end
			S_M2: begin
				mx = mul_a_q[63:32];
				my = mc[31:0];
			end
			default: begin
				mx = mul_a_q[31:0];
				my = mc[31:0];
			end
		endcase
		mprod = {32'b0, mx} * {32'b0, my};
	end

	// lane rotation for the merge sum
	always_comb begin
		case (k_q)
			2'd0: lane_rot = xxh64_pkg::rotl(lane_k, 6'd1);
			2'd1: lane_rot = xxh64_pkg::rotl(lane_k, 6'd7);
			2'd2: lane_rot = xxh64_pkg::rotl(lane_k, 6'd12);
			default: lane_rot = xxh64_pkg::rotl(lane_k, 6'd18);
		endcase
	end

	// stripe buffer, registered read
	always_ff @(posedge clk) begin
		if (acc_in && byte_in.byte_valid) begin
			mem[len_q[4:0]] <= byte_in.data_byte;
		end
		rd_q <= mem[ld_addr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			ret_q    <= S_IDLE;
			ld_ret_q <= S_IDLE;
			seed_q   <= '0;
			len_q    <= '0;
			h_q      <= '0;
			w_q      <= '0;
			p_q      <= '0;
			mul_a_q  <= '0;
			hash_q   <= '0;
			for (int i = 0; i < 4; i++) lane_q[i] <= '0;
			mc_q     <= xxh64_pkg::C_P1;
			start_q  <= 1'b1;
			pend_q   <= 1'b0;
			ov_q     <= 1'b0;
			k_q      <= '0;
			pos_q    <= '0;
			ld_addr_q <= '0;
			ld_cnt_q <= '0;
			ld_n_q   <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			// output beat taken; a hash handed over in the same cycle keeps it set
			if (ov_q && hash_out.ready && st_q != S_OUTW) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (acc_in) begin
						if (byte_in.byte_valid) begin
							if (start_q) begin
								lane_q[0] <= seed_q + xxh64_pkg::PRIME12;
								lane_q[1] <= seed_q + xxh64_pkg::PRIME2;
								lane_q[2] <= seed_q;
								lane_q[3] <= seed_q - xxh64_pkg::PRIME1;
							end
							start_q <= 1'b0;
							len_q   <= len_q + 64'd1;
							pend_q  <= byte_in.last;
							if (len_q[4:0] == 5'd31) begin
								k_q  <= '0;
								st_q <= S_SR0;
							end else if (byte_in.last) begin
								st_q <= S_FIN;
							end
						end else if (byte_in.last) begin
							st_q <= S_FIN;
						end
					end
				end
				// byte-serial word load, little-endian into the top of w_q
				S_LDA: st_q <= S_LDB;
				S_LDB: begin
					w_q       <= {rd_q, w_q[63:8]};
					ld_addr_q <= ld_addr_q + 5'd1;
					if (ld_cnt_q == ld_n_q - 4'd1) begin
						st_q <= ld_ret_q;
					end else begin
						ld_cnt_q <= ld_cnt_q + 4'd1;
						st_q     <= S_LDA;
					end
				end
				// multiply mul_a_q by the selected prime, low 64 bits
				S_M0: begin
					p_q  <= mprod;
					st_q <= S_M1;
				end
				S_M1: begin
					p_q  <= p_q + {mprod[31:0], 32'b0};
					st_q <= S_M2;
				end
				S_M2: begin
					p_q  <= p_q + {mprod[31:0], 32'b0};
					st_q <= ret_q;
				end
				// stripe: one lane round per lane
				S_SR0: begin
					ld_addr_q <= {k_q, 3'b000};
					ld_cnt_q  <= '0;
					ld_n_q    <= 4'd8;
					ld_ret_q  <= S_SR1;
					st_q      <= S_LDA;
				end
				S_SR1: begin
					mul_a_q <= w_q;
					mc_q    <= xxh64_pkg::C_P2;
					ret_q   <= S_SR2;
					st_q    <= S_M0;
				end
				S_SR2: begin
					mul_a_q <= xxh64_pkg::rotl(lane_k + p_q, 6'd31);
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_SR3;
					st_q    <= S_M0;
				end
				S_SR3: begin
					lane_q[k_q] <= p_q;
					k_q         <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						st_q <= pend_q ? S_FIN : S_IDLE;
					end else begin
						st_q <= S_SR0;
					end
				end
				// finish: lane merge or short-message start value
				S_FIN: begin
					k_q <= '0;
					if (len_q[63:5] != '0) begin
						h_q  <= '0;
						st_q <= S_MSUM;
					end else begin
						h_q  <= seed_q + xxh64_pkg::PRIME5;
						st_q <= S_FADD;
					end
				end
				S_MSUM: begin
					h_q <= h_q + lane_rot;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						st_q <= S_MG1;
					end
				end
				S_MG1: begin
					mul_a_q <= lane_k;
					mc_q    <= xxh64_pkg::C_P2;
					ret_q   <= S_MG2;
					st_q    <= S_M0;
				end
				S_MG2: begin
					mul_a_q <= xxh64_pkg::rotl(p_q, 6'd31);
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_MG3;
					st_q    <= S_M0;
				end
				S_MG3: begin
					mul_a_q <= h_q ^ p_q;
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_MG4;
					st_q    <= S_M0;
				end
				S_MG4: begin
					h_q <= p_q + xxh64_pkg::PRIME4;
					k_q <= k_q + 2'd1;
					st_q <= (k_q == 2'd3) ? S_FADD : S_MG1;
				end
				S_FADD: begin
					h_q   <= h_q + len_q;
					pos_q <= '0;
					st_q  <= S_TAIL;
				end
				// tail dispatch: 8-byte, then 4-byte, then single-byte steps
				S_TAIL: begin
					ld_addr_q <= pos_q[4:0];
					ld_cnt_q  <= '0;
					if (pos_q + 6'd8 <= {1'b0, tail}) begin
						ld_n_q   <= 4'd8;
						ld_ret_q <= S_T8A;
						st_q     <= S_LDA;
					end else if (pos_q + 6'd4 <= {1'b0, tail}) begin
						ld_n_q   <= 4'd4;
						ld_ret_q <= S_T4A;
						st_q     <= S_LDA;
					end else if (pos_q < {1'b0, tail}) begin
						ld_n_q   <= 4'd1;
						ld_ret_q <= S_T1A;
						st_q     <= S_LDA;
					end else begin
						st_q <= S_AV1;
					end
				end
				S_T8A: begin
					mul_a_q <= w_q;
					mc_q    <= xxh64_pkg::C_P2;
					ret_q   <= S_T8B;
					st_q    <= S_M0;
				end
				S_T8B: begin
					mul_a_q <= xxh64_pkg::rotl(p_q, 6'd31);
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_T8C;
					st_q    <= S_M0;
				end
				S_T8C: begin
					mul_a_q <= xxh64_pkg::rotl(h_q ^ p_q, 6'd27);
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_T8D;
					st_q    <= S_M0;
				end
				S_T8D: begin
					h_q   <= p_q + xxh64_pkg::PRIME4;
					pos_q <= pos_q + 6'd8;
					st_q  <= S_TAIL;
				end
				S_T4A: begin
					mul_a_q <= {32'b0, w_q[63:32]};
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_T4B;
					st_q    <= S_M0;
				end
				S_T4B: begin
					mul_a_q <= xxh64_pkg::rotl(h_q ^ p_q, 6'd23);
					mc_q    <= xxh64_pkg::C_P2;
					ret_q   <= S_T4C;
					st_q    <= S_M0;
				end
				S_T4C: begin
					h_q   <= p_q + xxh64_pkg::PRIME3;
					pos_q <= pos_q + 6'd4;
					st_q  <= S_TAIL;
				end
				S_T1A: begin
					mul_a_q <= {56'b0, w_q[63:56]};
					mc_q    <= xxh64_pkg::C_P5;
					ret_q   <= S_T1B;
					st_q    <= S_M0;
				end
				S_T1B: begin
					mul_a_q <= xxh64_pkg::rotl(h_q ^ p_q, 6'd11);
					mc_q    <= xxh64_pkg::C_P1;
					ret_q   <= S_T1C;
					st_q    <= S_M0;
				end
				S_T1C: begin
					h_q   <= p_q;
					pos_q <= pos_q + 6'd1;
					st_q  <= S_TAIL;
				end
				// avalanche
				S_AV1: begin
					mul_a_q <= h_q ^ (h_q >> 33);
					mc_q    <= xxh64_pkg::C_P2;
					ret_q   <= S_AV2;
					st_q    <= S_M0;
				end
				S_AV2: begin
					mul_a_q <= p_q ^ (p_q >> 29);
					mc_q    <= xxh64_pkg::C_P3;
					ret_q   <= S_AV3;
					st_q    <= S_M0;
				end
				S_AV3: begin
					h_q  <= p_q ^ (p_q >> 32);
					st_q <= S_OUTW;
				end
				// hand the hash to the output register once it is free
				S_OUTW: begin
					if (!ov_q || hash_out.ready) begin
						hash_q  <= h_q;
						ov_q    <= 1'b1;
						len_q   <= '0;
						start_q <= 1'b1;
						st_q    <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a fresh message has no bytes counted
	a_start_len: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (len_q == '0))
		else $error("message start flag set with nonzero length");

	// a closing beat makes the block busy next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && byte_in.last) |=> !byte_in.ready)
		else $error("block ready right after a last beat");

	// word loads never run past their byte count
	a_ld_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_LDB) |-> (ld_cnt_q < ld_n_q))
		else $error("load counter beyond word size");

	// a waiting hash is not overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !hash_out.ready) |=> (ov_q && $stable(hash_q)))
		else $error("pending hash lost");
`endif

endmodule

[verif/tb_xxh64_stream_hash.sv]
`timescale 1ns / 1ps

module tb_xxh64_stream_hash;

	localparam int SETTLE_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [63:0] cfg_wdata;

	xxh64_byte_if byte_bus ();
	xxh64_hash_if hash_bus ();

	xxh64_stream_hash DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_bus.sink),
		.hash_out  (hash_bus.source)
	);

	// expected hash plus optional hand-typed value
	typedef struct {
		logic [63:0] hash;
		logic        typed;
		logic [63:0] typed_hash;
	} hash_exp_t;

	hash_exp_t pending_hashes[$];

	// predictor state
	logic [63:0] seed_q = '0;
	logic [63:0] lanes[4] = '{default: '0};
	logic [7:0]  stripe[32] = '{default: '0};
	logic [63:0] msg_len = '0;
	logic        msg_fresh = 1'b1;

	logic byte_taken = 1'b0;
	logic cur_typed;
	logic [63:0] cur_typed_hash;
	logic idle_en;
	int   sink_idle = 0;
	bit   failed = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] rol(input logic [63:0] x, input int n);
		return (x << n) | (x >> (64 - n));
	endfunction

	function automatic logic [63:0] mix_round(input logic [63:0] acc, input logic [63:0] w);
		acc = acc + w * xxh64_pkg::PRIME2;
		acc = rol(acc, 31);
		return acc * xxh64_pkg::PRIME1;
	endfunction

	function automatic logic [63:0] stripe_word(input int pos, input int nbytes);
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < nbytes; i++)
			w |= 64'(stripe[(pos + i) & 31]) << (8 * i);
		return w;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		int slot;
		if (msg_fresh) begin
			lanes[0] = seed_q + xxh64_pkg::PRIME1 + xxh64_pkg::PRIME2;
			lanes[1] = seed_q + xxh64_pkg::PRIME2;
			lanes[2] = seed_q;
			lanes[3] = seed_q - xxh64_pkg::PRIME1;
			msg_fresh = 1'b0;
		end
		slot = int'(msg_len[4:0]);
		stripe[slot] = b;
		msg_len++;
		if (slot == 31)
			for (int k = 0; k < 4; k++)
				lanes[k] = mix_round(lanes[k], stripe_word(8 * k, 8));
	endfunction

	function automatic logic [63:0] digest(input int dummy);
		logic [63:0] h;
		int tail;
		int pos;
		tail = int'(msg_len[4:0]);
		pos = 0;
		if (msg_len >= 64'd32) begin
			h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12) + rol(lanes[3], 18);
			for (int k = 0; k < 4; k++) begin
				h ^= mix_round(64'd0, lanes[k]);
				h = h * xxh64_pkg::PRIME1 + xxh64_pkg::PRIME4;
			end
		end else begin
			h = seed_q + xxh64_pkg::PRIME5;
		end
		h += msg_len;
		while (pos + 8 <= tail) begin
			h ^= mix_round(64'd0, stripe_word(pos, 8));
			h = rol(h, 27) * xxh64_pkg::PRIME1 + xxh64_pkg::PRIME4;
			pos += 8;
		end
		if (pos + 4 <= tail) begin
			h ^= stripe_word(pos, 4) * xxh64_pkg::PRIME1;
			h = rol(h, 23) * xxh64_pkg::PRIME2 + xxh64_pkg::PRIME3;
			pos += 4;
		end
		while (pos < tail) begin
			h ^= 64'(stripe[pos]) * xxh64_pkg::PRIME5;
			h = rol(h, 11) * xxh64_pkg::PRIME1;
			pos++;
		end
		// avalanche
		h ^= h >> 33;
		h *= xxh64_pkg::PRIME2;
		h ^= h >> 29;
		h *= xxh64_pkg::PRIME3;
		h ^= h >> 32;
		return h;
	endfunction

	// predict on accepted beats, check accepted hashes
	always @(posedge clk) begin
		hash_exp_t e;
		if (cfg_we)
			seed_q = cfg_wdata;
		byte_taken = byte_bus.valid && byte_bus.ready;
		if (byte_taken) begin
			if (byte_bus.byte_valid)
				absorb_byte(byte_bus.data_byte);
			if (byte_bus.last) begin
				e.hash = digest(0);
				e.typed = cur_typed;
				e.typed_hash = cur_typed_hash;
				pending_hashes = {pending_hashes, e};
				msg_len = '0;
				msg_fresh = 1'b1;
			end
		end
		if (hash_bus.valid && hash_bus.ready) begin
			if (pending_hashes.size() == 0) begin
				$display("%0t: unexpected hash, expected none, actual %h", $time,
					hash_bus.hash_value);
				failed = 1'b1;
			end else begin
				e = pending_hashes.pop_front();
				if (hash_bus.hash_value !== e.hash) begin
					$display("%0t: hash_value mismatch, expected %h, actual %h", $time,
						e.hash, hash_bus.hash_value);
					failed = 1'b1;
				end else if (e.typed && hash_bus.hash_value !== e.typed_hash) begin
					$display("%0t: hash_value mismatch, expected %h, actual %h", $time,
						e.typed_hash, hash_bus.hash_value);
					failed = 1'b1;
				end
			end
		end
	end

	// result side back-pressure in bursts
	always @(negedge clk) begin
		if (sink_idle > 0) begin
			sink_idle--;
			hash_bus.ready = 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			sink_idle = $urandom_range(0, 6);
			hash_bus.ready = 1'b0;
		end else begin
			hash_bus.ready = 1'b1;
		end
	end

	task automatic send_beat(input logic [7:0] d, input logic bv, input logic l,
			input logic typed, input logic [63:0] typed_hash);
		int gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 7);
			byte_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_bus.valid = 1'b1;
		byte_bus.data_byte = d;
		byte_bus.byte_valid = bv;
		byte_bus.last = l;
		cur_typed = typed;
		cur_typed_hash = typed_hash;
		do @(negedge clk); while (!byte_taken);
	endtask

	// block idle: results drained plus time for stripe rounds
	task automatic settle();
		byte_bus.valid = 1'b0;
		while (pending_hashes.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_seed(input logic [63:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	typedef struct {
		logic [7:0]  d;
		logic        bv;
		logic        l;
		logic        typed;
		logic [63:0] typed_hash;
		logic        wr;
		logic [63:0] wval;
	} beat_row_t;

	beat_row_t directed[14] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, 64'hEF46DB3751D8E999, 1'b0, 64'd0}, // empty message
		'{8'hAA, 1'b0, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},                // ignored beat
		'{8'h61, 1'b1, 1'b1, 1'b1, 64'hD24EC4F1A98C6E5B, 1'b0, 64'd0}, // byte with last
		'{8'h61, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},
		'{8'h62, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},
		'{8'h63, 1'b1, 1'b1, 1'b1, 64'h44BC2CF5AD770999, 1'b0, 64'd0},
		'{8'hFF, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},
		'{8'h00, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},
		'{8'hFF, 1'b0, 1'b1, 1'b0, 64'd0, 1'b0, 64'd0},                // last, byte ignored
		'{8'h00, 1'b0, 1'b1, 1'b0, 64'd0, 1'b1, 64'hFFFFFFFFFFFFFFFF},
		'{8'hFF, 1'b1, 1'b1, 1'b0, 64'd0, 1'b0, 64'd0},
		'{8'h01, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},
		'{8'h02, 1'b1, 1'b0, 1'b0, 64'd0, 1'b0, 64'd0},
		// seed changed mid-message, short message takes the new one
		'{8'h03, 1'b1, 1'b1, 1'b0, 64'd0, 1'b1, 64'h123456789ABCDEF0}
	};

	initial begin
		int sent;
		int mlen;
		logic [63:0] s;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = '0;
		byte_bus.byte_valid = 1'b0;
		byte_bus.last = 1'b0;
		idle_en = 1'b1;
		cur_typed = 1'b0;
		cur_typed_hash = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].wr) begin
				settle();
				write_seed(directed[i].wval);
			end
			send_beat(directed[i].d, directed[i].bv, directed[i].l,
				directed[i].typed, directed[i].typed_hash);
		end

		// random messages, mostly short, some past one, two or three stripes
		sent = 0;
		while (sent < 1780) begin
			if (sent > 1500)
				idle_en = 1'b0;
			if ($urandom_range(0, 5) == 0) begin
				settle();
				case ($urandom_range(0, 3))
					0: s = '0;
					1: s = '1;
					default: s = {$urandom, $urandom};
				endcase
				write_seed(s);
			end
			mlen = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 100)
				: $urandom_range(0, 40);
			for (int i = 0; i < mlen; i++) begin
				if ($urandom_range(0, 19) == 0)
					send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
				if (i == mlen / 2 && $urandom_range(0, 15) == 0) begin
					settle();
					write_seed({$urandom, $urandom});
				end
				if (i == mlen - 1 && $urandom_range(0, 1) == 0)
					send_beat(8'($urandom), 1'b1, 1'b1, 1'b0, '0);
				else
					send_beat(8'($urandom), 1'b1, 1'b0, 1'b0, '0);
				sent++;
			end
			if (mlen == 0 || !byte_bus.last)
				send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
		end

		settle();
		if (!failed && pending_hashes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
design/xxh64_pkg.sv
design/xxh64_ifs.sv
design/xxh64_stream_hash.sv
verif/tb_xxh64_stream_hash.sv
